FILE: hdl/reader_writer_lock_table_core_assert.svh
// Assertion macros for the lock table core.
// Expects signals clk and arst_n in the scope of use.
`ifndef READER_WRITER_LOCK_TABLE_CORE_ASSERT_SVH
`define READER_WRITER_LOCK_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RWLT_ASSERT_HOLD(label, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("rwlt assertion failed");
`define RWLT_ASSERT_NEXT(label, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("rwlt assertion failed");
`else
`define RWLT_ASSERT_HOLD(label, ant, cons)
`define RWLT_ASSERT_NEXT(label, ant, cons)
`endif
`endif

FILE: hdl/rwlt_pkg.sv
// Package for the reader/writer lock table: item types, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
package rwlt_pkg;

	localparam int LOCK_COUNT_DEF  = 16;
	localparam int READER_BITS_DEF = 16;
	localparam int WAITER_BITS_DEF = 8;
	localparam int READERS_NOW_W   = 16;
	localparam int WAITERS_NOW_W   = 8;

	typedef enum logic [2:0] {
		ACT_TRY_READ   = 3'd0,
		ACT_READ_REL   = 3'd1,
		ACT_WR_REG     = 3'd2,
		ACT_WR_ATTEMPT = 3'd3,
		ACT_TRY_WRITE  = 3'd4,
		ACT_WRITE_REL  = 3'd5,
		ACT_CLEAR      = 3'd6
	} rwlt_action_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_BUSY = 2'd1,
		ST_ERR  = 2'd2
	} rwlt_status_t;

	typedef enum logic {
		MODE_CLEAR,
		MODE_RUN
	} rwlt_mode_t;

	typedef struct packed {
		logic [2:0] action;
		logic [3:0] lock_index;
	} rwlt_req_t;

	typedef struct packed {
		logic                     granted;
		rwlt_status_t             status;
		logic [READERS_NOW_W-1:0] readers_now;
		logic [WAITERS_NOW_W-1:0] waiters_now;
		logic                     writer_now;
	} rwlt_rsp_t;

	typedef struct packed {
		logic         granted;
		rwlt_status_t status;
	} rwlt_flags_t;

endpackage

FILE: hdl/rwlt_mem.sv
// Lock entry memory: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps
module rwlt_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 25,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/rwlt_update.sv
// Entry update logic: applies one action to a lock entry.
// Depends on rwlt_pkg.
`timescale 1ns / 1ps
module rwlt_update #(
	parameter int READER_BITS = 16,
	parameter int WAITER_BITS = 8,
	parameter int EW          = READER_BITS + WAITER_BITS + 1
) (
	input  logic [2:0]           action,
	input  logic [EW-1:0]        entry,
	output logic [EW-1:0]        entry_nxt,
	output rwlt_pkg::rwlt_flags_t flags
);

	logic [READER_BITS-1:0] rd, rd_nxt;
	logic [WAITER_BITS-1:0] wt, wt_nxt;
	logic                   wr, wr_nxt;

	assign rd = entry[READER_BITS-1:0];
	assign wt = entry[READER_BITS+WAITER_BITS-1:READER_BITS];
	assign wr = entry[EW-1];

	always_comb begin
		rd_nxt        = rd;
		wt_nxt        = wt;
		wr_nxt        = wr;
		flags.granted = 1'b0;
		flags.status  = rwlt_pkg::ST_ERR;
		case (action)
			rwlt_pkg::ACT_TRY_READ: begin
				if (wr || (|wt)) begin
					flags.status = rwlt_pkg::ST_BUSY;
				end else if (&rd) begin
					flags.status = rwlt_pkg::ST_ERR;
				end else begin
					rd_nxt        = rd + 1'b1;
					flags.granted = 1'b1;
					flags.status  = rwlt_pkg::ST_DONE;
				end
			end
			rwlt_pkg::ACT_READ_REL: begin
				if (rd != '0) begin
					rd_nxt        = rd - 1'b1;
					flags.granted = 1'b1;
					flags.status  = rwlt_pkg::ST_DONE;
				end
			end
			rwlt_pkg::ACT_WR_REG: begin
				if (!(&wt)) begin
					wt_nxt        = wt + 1'b1;
					flags.granted = 1'b1;
					flags.status  = rwlt_pkg::ST_DONE;
				end
			end
			rwlt_pkg::ACT_WR_ATTEMPT: begin
				if (wt == '0) begin
					flags.status = rwlt_pkg::ST_ERR;
				end else if (wr || (|rd)) begin
					flags.status = rwlt_pkg::ST_BUSY;
				end else begin
					wt_nxt        = wt - 1'b1;
					wr_nxt        = 1'b1;
					flags.granted = 1'b1;
					flags.status  = rwlt_pkg::ST_DONE;
				end
			end
			rwlt_pkg::ACT_TRY_WRITE: begin
				if (wr || (|wt) || (|rd)) begin
					flags.status = rwlt_pkg::ST_BUSY;
				end else begin
					wr_nxt        = 1'b1;
					flags.granted = 1'b1;
					flags.status  = rwlt_pkg::ST_DONE;
				end
			end
			rwlt_pkg::ACT_WRITE_REL: begin
				if (wr) begin
					wr_nxt        = 1'b0;
					flags.granted = 1'b1;
					flags.status  = rwlt_pkg::ST_DONE;
				end
			end
			rwlt_pkg::ACT_CLEAR: begin
				rd_nxt        = '0;
				wt_nxt        = '0;
				wr_nxt        = 1'b0;
				flags.granted = 1'b1;
				flags.status  = rwlt_pkg::ST_DONE;
			end
			default: begin
				flags.status = rwlt_pkg::ST_ERR;
			end
		endcase
	end

	assign entry_nxt = {wr_nxt, wt_nxt, rd_nxt};

endmodule

FILE: hdl/reader_writer_lock_table_core.sv
// Reader/writer lock table top level: entry memory, update logic, output register.
// Depends on rwlt_pkg, rwlt_mem, rwlt_update and reader_writer_lock_table_core_assert.svh.
//
// Usage:
//   Request channel (req_valid/req_ready/req) carries one item: an action and a
//   lock index. Response channel (rsp_valid/rsp_ready/rsp) returns one item per
//   request: granted, status and the entry contents after the update.
//   Timing: an accepted request is registered together with its memory read,
//   and its response is then registered in the output register.
//   Throughput: one item per cycle unless the response stalls. The entry is
//   read from the memory at the accept edge and written back when its response
//   is registered; a request accepted at that edge takes the written value
//   from a bypass register, so back-to-back requests to one lock need no bubble.
//   Reset: the memory is cleared by a pass over all LOCK_COUNT entries, one entry a
//   cycle; req_ready stays low until the pass is done.
//   Stall: when rsp_ready is low, the response is held in its register, one
//   more request may be accepted and read, then req_ready drops until the
//   response is taken.
//   Indexes at or beyond LOCK_COUNT return an error with zero counts.
`timescale 1ns / 1ps
`include "reader_writer_lock_table_core_assert.svh"
module reader_writer_lock_table_core #(
	parameter int LOCK_COUNT  = rwlt_pkg::LOCK_COUNT_DEF,
	parameter int READER_BITS = rwlt_pkg::READER_BITS_DEF,
	parameter int WAITER_BITS = rwlt_pkg::WAITER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rwlt_pkg::rwlt_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rwlt_pkg::rwlt_rsp_t rsp
);

	localparam int EW = READER_BITS + WAITER_BITS + 1;
	localparam int AW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(LOCK_COUNT - 1);

	rwlt_pkg::rwlt_mode_t  mode_q, mode_d;
	logic                  clearing;
	logic [AW-1:0]         clr_addr_q;

	logic                  accept, adv;
	logic [31:0]           idx_ext;
	logic                  in_range;
	logic [AW-1:0]         req_addr;

	logic                  valid_s1;
	logic [2:0]            action_s1;
	logic [AW-1:0]         addr_s1;
	logic                  inrange_s1;

	logic                  fwd_valid_q;
	logic [AW-1:0]         fwd_addr_q;
	logic [EW-1:0]         fwd_data_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [EW-1:0]         mem_wdata;
	logic [EW-1:0]         mem_rdata;
	logic [EW-1:0]         entry_cur, entry_nxt;
	rwlt_pkg::rwlt_flags_t flags;

	logic                  out_valid_q;
	rwlt_pkg::rwlt_rsp_t   rsp_q, rsp_d;
	logic [31:0]           rd_ext, wt_ext;

	// reset clear pass
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			rwlt_pkg::MODE_CLEAR: begin
				if (clr_addr_q == LAST_ADDR) begin
					mode_d = rwlt_pkg::MODE_RUN;
				end
			end
			rwlt_pkg::MODE_RUN: begin
				mode_d = rwlt_pkg::MODE_RUN;
			end
			default: begin
				mode_d = rwlt_pkg::MODE_CLEAR;
			end
		endcase
	end

	always_comb begin
		case (mode_q)
			rwlt_pkg::MODE_CLEAR: clearing = 1'b1;
			rwlt_pkg::MODE_RUN:   clearing = 1'b0;
			default:              clearing = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= rwlt_pkg::MODE_CLEAR;
			clr_addr_q <= '0;
		end else begin
			mode_q <= mode_d;
			if (clearing) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// request side
	assign adv       = !out_valid_q || rsp_ready;
	assign req_ready = !clearing && (!valid_s1 || adv);
	assign accept    = req_valid && req_ready;
	assign idx_ext   = 32'(req.lock_index);
	assign in_range  = (idx_ext < 32'(LOCK_COUNT));
	assign req_addr  = in_range ? idx_ext[AW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= req.action;
			addr_s1    <= req_addr;
			inrange_s1 <= in_range;
		end
	end

	// memory and write-back
	assign mem_we    = clearing || (valid_s1 && adv && inrange_s1);
	assign mem_waddr = clearing ? clr_addr_q : addr_s1;
	assign mem_wdata = clearing ? '0 : entry_nxt;

	rwlt_mem #(
		.DEPTH(LOCK_COUNT),
		.WIDTH(EW),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(req_addr),
		.rdata(mem_rdata)
	);

	// last write bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (mem_we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fwd_addr_q <= mem_waddr;
			fwd_data_q <= mem_wdata;
		end
	end

	assign entry_cur = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : mem_rdata;

	rwlt_update #(
		.READER_BITS(READER_BITS),
		.WAITER_BITS(WAITER_BITS),
		.EW         (EW)
	) u_update (
		.action   (action_s1),
		.entry    (entry_cur),
		.entry_nxt(entry_nxt),
		.flags    (flags)
	);

	// response
	assign rd_ext = 32'(entry_nxt[READER_BITS-1:0]);
	assign wt_ext = 32'(entry_nxt[READER_BITS+WAITER_BITS-1:READER_BITS]);

	always_comb begin
		if (inrange_s1) begin
			rsp_d.granted     = flags.granted;
			rsp_d.status      = flags.status;
			rsp_d.readers_now = rd_ext[rwlt_pkg::READERS_NOW_W-1:0];
			rsp_d.waiters_now = wt_ext[rwlt_pkg::WAITERS_NOW_W-1:0];
			rsp_d.writer_now  = entry_nxt[EW-1];
		end else begin
			rsp_d.granted     = 1'b0;
			rsp_d.status      = rwlt_pkg::ST_ERR;
			rsp_d.readers_now = '0;
			rsp_d.waiters_now = '0;
			rsp_d.writer_now  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	`RWLT_ASSERT_HOLD(a_no_accept_clear, clearing, !req_ready)
	`RWLT_ASSERT_HOLD(a_grant_done, rsp_valid && rsp.granted, rsp.status == rwlt_pkg::ST_DONE)
	`RWLT_ASSERT_HOLD(a_no_write_oor, valid_s1 && !inrange_s1 && !clearing, !mem_we)
	`RWLT_ASSERT_NEXT(a_issue_result, valid_s1 && adv, rsp_valid)

endmodule

FILE: sim/tb_top.sv
// Testbench for the reader/writer lock table core: random and directed lock requests,
// with a shadow copy of the lock table that predicts every response.
// Depends on rwlt_pkg and reader_writer_lock_table_core.
`timescale 1ns / 1ps
module tb_top;

	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam int         HOT_LOCKS  = 4;
	localparam int         HOLD_LEN   = 80;
	localparam int         RAND_ITEMS = 650;

	typedef struct packed {
		logic                               writer;
		logic [rwlt_pkg::WAITERS_NOW_W-1:0] waiters;
		logic [rwlt_pkg::READERS_NOW_W-1:0] readers;
	} lock_entry_t;

	class lock_table_shadow;
		lock_entry_t         entries [rwlt_pkg::LOCK_COUNT_DEF];
		rwlt_pkg::rwlt_rsp_t pending_results [$];
		int                  mismatches;

		function new();
			foreach (entries[i]) entries[i] = '0;
			mismatches = 0;
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		// Apply one accepted request to the shadow table and queue the response it implies.
		function void apply_request(rwlt_pkg::rwlt_req_t r);
			lock_entry_t         e;
			rwlt_pkg::rwlt_rsp_t x;
			x = '0;
			x.status = rwlt_pkg::ST_ERR;
			if (r.lock_index >= rwlt_pkg::LOCK_COUNT_DEF) begin
				pending_results.push_back(x);
				return;
			end
			e = entries[r.lock_index];
			case (r.action)
				rwlt_pkg::ACT_TRY_READ: begin
					if (e.writer || e.waiters != 0) x.status = rwlt_pkg::ST_BUSY;
					else if (e.readers != '1) begin
						e.readers++;
						x.granted = 1'b1;
						x.status = rwlt_pkg::ST_DONE;
					end
				end
				rwlt_pkg::ACT_READ_REL: begin
					if (e.readers != 0) begin
						e.readers--;
						x.granted = 1'b1;
						x.status = rwlt_pkg::ST_DONE;
					end
				end
				rwlt_pkg::ACT_WR_REG: begin
					if (e.waiters != '1) begin
						e.waiters++;
						x.granted = 1'b1;
						x.status = rwlt_pkg::ST_DONE;
					end
				end
				rwlt_pkg::ACT_WR_ATTEMPT: begin
					if (e.waiters == 0) x.status = rwlt_pkg::ST_ERR;
					else if (e.writer || e.readers != 0) x.status = rwlt_pkg::ST_BUSY;
					else begin
						e.waiters--;
						e.writer = 1'b1;
						x.granted = 1'b1;
						x.status = rwlt_pkg::ST_DONE;
					end
				end
				rwlt_pkg::ACT_TRY_WRITE: begin
					if (e != '0) x.status = rwlt_pkg::ST_BUSY;
					else begin
						e.writer = 1'b1;
						x.granted = 1'b1;
						x.status = rwlt_pkg::ST_DONE;
					end
				end
				rwlt_pkg::ACT_WRITE_REL: begin
					if (e.writer) begin
						e.writer = 1'b0;
						x.granted = 1'b1;
						x.status = rwlt_pkg::ST_DONE;
					end
				end
				rwlt_pkg::ACT_CLEAR: begin
					e = '0;
					x.granted = 1'b1;
					x.status = rwlt_pkg::ST_DONE;
				end
				default: ;
			endcase
			entries[r.lock_index] = e;
			x.readers_now = e.readers;
			x.waiters_now = e.waiters;
			x.writer_now = e.writer;
			pending_results.push_back(x);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void match_result(rwlt_pkg::rwlt_rsp_t got);
			rwlt_pkg::rwlt_rsp_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response, expected none actual %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			check_field("granted", want.granted, got.granted);
			check_field("status", want.status, got.status);
			check_field("readers_now", want.readers_now, got.readers_now);
			check_field("waiters_now", want.waiters_now, got.waiters_now);
			check_field("writer_now", want.writer_now, got.writer_now);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	rwlt_pkg::rwlt_req_t req;
	logic                rsp_valid;
	logic                rsp_ready;
	rwlt_pkg::rwlt_rsp_t rsp;

	lock_table_shadow shadow = new;
	bit steady;
	bit tx_calm;
	bit rx_calm;
	int rx_hold_cycles;
	int items_sent;

	reader_writer_lock_table_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Idle cycles before the next item; calm stretches give back-to-back traffic.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 39) == 0) calm = !calm;
		if (calm || steady) return 0;
		return $urandom_range(0, 4);
	endfunction

	task automatic issue(logic [2:0] act, logic [3:0] idx);
		rwlt_pkg::rwlt_req_t r;
		int                  gap;
		r.action = act;
		r.lock_index = idx;
		gap = draw_wait(tx_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		shadow.apply_request(r);
		items_sent++;
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (shadow.outstanding() != 0);
	endtask

	initial begin
		int stall;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(rx_calm);
			if (rx_hold_cycles > 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			shadow.match_result(rsp);
		end
	end

	initial begin
		int  lk;
		int  k;
		bit  held;
		bit  paused;
		int  base;
		req_valid <= 1'b0;
		req <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed walk through every action and every refusal but counter saturation, on lock 15 then lock 0
		issue(rwlt_pkg::ACT_READ_REL, 4'd15);
		issue(rwlt_pkg::ACT_WRITE_REL, 4'd15);
		issue(rwlt_pkg::ACT_WR_ATTEMPT, 4'd15);
		issue(ACT_UNUSED, 4'd15);
		issue(rwlt_pkg::ACT_TRY_READ, 4'd15);
		issue(rwlt_pkg::ACT_TRY_WRITE, 4'd15);
		issue(rwlt_pkg::ACT_WR_REG, 4'd15);
		issue(rwlt_pkg::ACT_TRY_READ, 4'd15);
		issue(rwlt_pkg::ACT_WR_ATTEMPT, 4'd15);
		issue(rwlt_pkg::ACT_READ_REL, 4'd15);
		issue(rwlt_pkg::ACT_WR_ATTEMPT, 4'd15);
		issue(rwlt_pkg::ACT_TRY_READ, 4'd15);
		issue(rwlt_pkg::ACT_WR_REG, 4'd15);
		issue(rwlt_pkg::ACT_WR_ATTEMPT, 4'd15);
		issue(ACT_UNUSED, 4'd15);
		issue(rwlt_pkg::ACT_WRITE_REL, 4'd15);
		issue(rwlt_pkg::ACT_WR_ATTEMPT, 4'd15);
		issue(rwlt_pkg::ACT_TRY_WRITE, 4'd15);
		issue(rwlt_pkg::ACT_WRITE_REL, 4'd15);
		issue(rwlt_pkg::ACT_TRY_WRITE, 4'd15);
		issue(rwlt_pkg::ACT_CLEAR, 4'd15);
		issue(rwlt_pkg::ACT_TRY_WRITE, 4'd0);
		issue(rwlt_pkg::ACT_CLEAR, 4'd0);

		// waiter counter saturation
		steady = 1'b1;
		repeat (255) issue(rwlt_pkg::ACT_WR_REG, 4'd3);
		issue(rwlt_pkg::ACT_WR_REG, 4'd3);
		issue(rwlt_pkg::ACT_TRY_READ, 4'd3);
		issue(rwlt_pkg::ACT_WR_ATTEMPT, 4'd3);
		issue(rwlt_pkg::ACT_CLEAR, 4'd3);
		steady = 1'b0;

		// random lock sessions, mostly on a few hot locks
		held = 1'b0;
		paused = 1'b0;
		base = items_sent;
		while (items_sent - base < RAND_ITEMS) begin
			if (!held && items_sent - base >= 200) begin
				rx_hold_cycles = HOLD_LEN;
				held = 1'b1;
			end
			if (!paused && items_sent - base >= 500) begin
				drain_results();
				paused = 1'b1;
			end
			lk = ($urandom_range(0, 9) < 7) ? $urandom_range(0, HOT_LOCKS - 1)
				: $urandom_range(0, rwlt_pkg::LOCK_COUNT_DEF - 1);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					k = $urandom_range(1, 4);
					repeat (k) issue(rwlt_pkg::ACT_TRY_READ, 4'(lk));
					if ($urandom_range(0, 9) < 7)
						repeat (k) issue(rwlt_pkg::ACT_READ_REL, 4'(lk));
				end
				4, 5: begin
					issue(rwlt_pkg::ACT_WR_REG, 4'(lk));
					repeat ($urandom_range(1, 3)) issue(rwlt_pkg::ACT_WR_ATTEMPT, 4'(lk));
					if ($urandom_range(0, 9) < 8) issue(rwlt_pkg::ACT_WRITE_REL, 4'(lk));
				end
				6, 7: begin
					issue(rwlt_pkg::ACT_TRY_WRITE, 4'(lk));
					if ($urandom_range(0, 9) < 8) issue(rwlt_pkg::ACT_WRITE_REL, 4'(lk));
				end
				8: repeat ($urandom_range(1, 3))
					issue(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
				default: issue(rwlt_pkg::ACT_CLEAR, 4'(lk));
			endcase
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#(600000 * 12);
		$display("TB_ERROR");
		$finish;
	end

endmodule
